@@ hw/rtl/indexed_insert_delete_array_defines.svh @@
// Assertion helpers for the indexed insert/delete array.
// Both sample on clk and are disabled while rst_n is low.
`ifndef INDEXED_INSERT_DELETE_ARRAY_DEFINES_SVH
`define INDEXED_INSERT_DELETE_ARRAY_DEFINES_SVH

`ifndef SYNTHESIS
`define IIDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define IIDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IIDA_ASSERT_NOW(label, ante, cons, msg)
`define IIDA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ hw/rtl/iida_pkg.sv @@
package iida_pkg;

  localparam int REQ_W     = 3;
  localparam int POS_W     = 5;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int LEN_OUT_W = 5;

  typedef logic [REQ_W-1:0]  req_code_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam req_code_t REQ_READ    = 3'd0;
  localparam req_code_t REQ_APPEND  = 3'd1;
  localparam req_code_t REQ_PREPEND = 3'd2;
  localparam req_code_t REQ_INSERT  = 3'd3;
  localparam req_code_t REQ_DELETE  = 3'd4;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  // Per-cycle command broadcast along the cell chain.
  typedef struct packed {
    logic ins_en;
    logic del_en;
  } cell_ctl_t;

endpackage

@@ hw/rtl/iida_ifs.sv @@
interface iida_in_if;
  logic                      valid;
  logic                      ready;
  logic [iida_pkg::REQ_W-1:0] req_type;
  logic [iida_pkg::POS_W-1:0] position;
  logic signed [iida_pkg::VAL_W-1:0] value_in;

  modport source (output valid, output req_type, output position, output value_in,
                  input ready);
  modport sink   (input valid, input req_type, input position, input value_in,
                  output ready);
endinterface

interface iida_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [iida_pkg::VAL_W-1:0] value_out;
  logic [iida_pkg::STAT_W-1:0]       status;
  logic [iida_pkg::LEN_OUT_W-1:0]    length_after;

  modport source (output valid, output value_out, output status, output length_after,
                  input ready);
  modport sink   (input valid, input value_out, input status, input length_after,
                  output ready);
endinterface

@@ hw/rtl/indexed_insert_delete_array.sv @@
// Bounded ordered list of DEPTH signed words held in a chain of cells, one word per
// cell. Every request (read, append, prepend, insert at index, delete at index)
// is done in the cycle of its transfer, when all cells shift or hold together,
// and the result leaves from an output register the cycle after, so a new request
// is taken every cycle while the result side keeps up. Reads select the cell at the
// requested index. Words are stored at DATA_WIDTH bits and come back sign-extended
// to 32. A full list rejects additions with status 1, bad indices give status 2.
// The list is empty after reset; no clearing pass is needed.
`include "indexed_insert_delete_array_defines.svh"

module indexed_insert_delete_array #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic   clk,
  input logic   rst_n,
  iida_in_if.sink    in_chan,
  iida_out_if.source out_chan
);

  localparam int LW    = $clog2(DEPTH + 1);
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = (LW > iida_pkg::POS_W) ? LW : iida_pkg::POS_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  logic [LW-1:0]                       len_r, len_nxt;
  logic                                out_valid_r;
  logic signed [iida_pkg::VAL_W-1:0]   out_val_r, val_nxt;
  iida_pkg::status_t                   out_stat_r, stat_nxt;
  logic [iida_pkg::LEN_OUT_W-1:0]      out_len_r;

  logic                  fire;
  iida_pkg::cell_ctl_t   ctl, ctl_cmd;
  logic [CMP_W-1:0]      pos_x, len_x, cmd_pos;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] q [DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_word;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign fire          = in_chan.valid && in_chan.ready;

  assign pos_x   = CMP_W'(in_chan.position);
  assign len_x   = CMP_W'(len_r);
  assign word    = DATA_WIDTH'(in_chan.value_in);
  assign rd_word = signed'(q[pos_x[IW-1:0]]);

  always_comb begin
    ctl_cmd  = '0;
    cmd_pos  = pos_x;
    val_nxt  = '0;
    stat_nxt = iida_pkg::ST_DONE;
    len_nxt  = len_r;
    unique case (in_chan.req_type)
      iida_pkg::REQ_READ: begin
        if (pos_x < len_x) begin
          val_nxt = iida_pkg::VAL_W'(rd_word);
        end else begin
          stat_nxt = iida_pkg::ST_RANGE;
        end
      end
      iida_pkg::REQ_APPEND, iida_pkg::REQ_PREPEND, iida_pkg::REQ_INSERT: begin
        if (in_chan.req_type == iida_pkg::REQ_APPEND) begin
          cmd_pos = len_x;
        end else if (in_chan.req_type == iida_pkg::REQ_PREPEND) begin
          cmd_pos = '0;
        end
        // index check comes before the full check
        if (in_chan.req_type == iida_pkg::REQ_INSERT && pos_x > len_x) begin
          stat_nxt = iida_pkg::ST_RANGE;
        end else if (len_x == DEPTH_C) begin
          stat_nxt = iida_pkg::ST_FULL;
        end else begin
          ctl_cmd.ins_en = 1'b1;
          len_nxt        = LW'(len_r + 1'b1);
        end
      end
      iida_pkg::REQ_DELETE: begin
        if (pos_x >= len_x) begin
          stat_nxt = iida_pkg::ST_RANGE;
        end else begin
          ctl_cmd.del_en = 1'b1;
          len_nxt        = LW'(len_r - 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl.ins_en = fire && ctl_cmd.ins_en;
  assign ctl.del_en = fire && ctl_cmd.del_en;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (i == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_left
      assign left_w = q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_right
      assign right_w = q[i+1];
    end
    iida_cell #(
      .IDX (i),
      .W   (DATA_WIDTH),
      .CW  (CMP_W)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .pos   (cmd_pos),
      .len   (len_x),
      .word  (word),
      .left  (left_w),
      .right (right_w),
      .q     (q[i])
    );
  end

  logic [CMP_W-1:0] len_nxt_x;
  assign len_nxt_x = CMP_W'(len_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        len_r       <= len_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (fire) begin
      out_val_r  <= val_nxt;
      out_stat_r <= stat_nxt;
      out_len_r  <= len_nxt_x[iida_pkg::LEN_OUT_W-1:0];
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.value_out    = out_val_r;
  assign out_chan.status       = out_stat_r;
  assign out_chan.length_after = out_len_r;

  logic                           rejected;
  logic [iida_pkg::LEN_OUT_W-1:0] len_echo;
  assign rejected = fire && (stat_nxt != iida_pkg::ST_DONE);
  assign len_echo = len_x[iida_pkg::LEN_OUT_W-1:0];

  `IIDA_ASSERT_NOW(a_len_bound, 1'b1, len_x <= DEPTH_C, "length exceeds depth")
  `IIDA_ASSERT_NEXT(a_fire_valid, fire, out_valid_r, "transfer without result")
  `IIDA_ASSERT_NEXT(a_reject_hold, rejected, $stable(len_r), "rejected request changed length")
  `IIDA_ASSERT_NOW(a_len_echo, out_valid_r, out_len_r == len_echo, "reported length differs")

endmodule

@@ hw/rtl/iida_cell.sv @@
module iida_cell #(
  parameter int IDX = 0,
  parameter int W   = 32,
  parameter int CW  = 5
) (
  input  logic                clk,
  input  iida_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]       pos,
  input  logic [CW-1:0]       len,
  input  logic [W-1:0]        word,
  input  logic [W-1:0]        left,
  input  logic [W-1:0]        right,
  output logic [W-1:0]        q
);

  localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
  localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);

  logic [W-1:0] q_r;
  logic [W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.ins_en) begin
      if (MY_IDX == pos) begin
        q_nxt = word;
      end else if (MY_IDX > pos && MY_IDX <= len) begin
        q_nxt = left;
      end
    end else if (ctl.del_en) begin
      // cells from the deleted slot up to the new tail pull from above
      if (MY_IDX >= pos && NEXT_IDX < len) begin
        q_nxt = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

@@ tb/indexed_insert_delete_array_tb.sv @@
`timescale 1ns / 1ps

module indexed_insert_delete_array_tb;

  localparam int LIST_DEPTH    = 16;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;

  // codes the block does not decode; they must leave the list alone
  localparam iida_pkg::req_code_t REQ_SPARE_LO = 3'd5;
  localparam iida_pkg::req_code_t REQ_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [iida_pkg::VAL_W-1:0] value;
    iida_pkg::status_t                 status;
    logic [iida_pkg::LEN_OUT_W-1:0]    len;
  } list_result_t;

  typedef struct packed {
    iida_pkg::req_code_t            req;
    logic [iida_pkg::POS_W-1:0]     pos;
    logic [iida_pkg::VAL_W-1:0]     val;
    logic [3:0]                     reps;
    logic                           typed;
    logic [iida_pkg::VAL_W-1:0]     exp_value;
    iida_pkg::status_t              exp_status;
    logic [iida_pkg::LEN_OUT_W-1:0] exp_len;
  } directed_row_t;

  logic clk;
  logic rst_n;

  iida_in_if  in_chan();
  iida_out_if out_chan();

  indexed_insert_delete_array u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // list mirror
  logic signed [iida_pkg::VAL_W-1:0] list_words [0:LIST_DEPTH-1];
  int                                list_len;
  int                                peak_len;

  list_result_t pending_results [$];

  int cycles;
  int requests_sent;
  int directed_sent;
  int results_checked;
  int failures;
  int full_hits;
  int range_hits;
  bit send_quiet;
  bit sink_quiet;

  // rows with a typed expectation are read straight off the list behavior
  directed_row_t plan [0:24] = '{
    '{iida_pkg::REQ_READ,    5'd0,  32'h0, 4'd1,  1'b1, 32'h0, iida_pkg::ST_RANGE, 5'd0},
    '{iida_pkg::REQ_DELETE,  5'd0,  32'h0, 4'd1,  1'b1, 32'h0, iida_pkg::ST_RANGE, 5'd0},
    '{iida_pkg::REQ_INSERT,  5'd1,  32'h5, 4'd1,  1'b1, 32'h0, iida_pkg::ST_RANGE, 5'd0},
    '{REQ_SPARE_LO,          5'd0,  32'hdead_beef, 4'd1,  1'b1, 32'h0, iida_pkg::ST_DONE, 5'd0},
    '{iida_pkg::REQ_APPEND,  5'd0,  32'h7fff_ffff, 4'd1,  1'b1, 32'h0, iida_pkg::ST_DONE, 5'd1},
    '{iida_pkg::REQ_PREPEND, 5'd0,  32'h8000_0000, 4'd1,  1'b1, 32'h0, iida_pkg::ST_DONE, 5'd2},
    '{iida_pkg::REQ_READ,    5'd0,  32'h0, 4'd1,  1'b1, 32'h8000_0000, iida_pkg::ST_DONE, 5'd2},
    '{iida_pkg::REQ_READ,    5'd1,  32'h0, 4'd1,  1'b1, 32'h7fff_ffff, iida_pkg::ST_DONE, 5'd2},
    '{iida_pkg::REQ_INSERT,  5'd1,  32'hffff_ffff, 4'd1,  1'b1, 32'h0, iida_pkg::ST_DONE, 5'd3},
    '{iida_pkg::REQ_INSERT,  5'd3,  32'h0, 4'd1,  1'b1, 32'h0, iida_pkg::ST_DONE,  5'd4},
    '{iida_pkg::REQ_READ,    5'd2,  32'h0, 4'd1,  1'b0, 32'h0, iida_pkg::ST_DONE,  5'd0},
    '{iida_pkg::REQ_READ,    5'd4,  32'h0, 4'd1,  1'b1, 32'h0, iida_pkg::ST_RANGE, 5'd4},
    '{iida_pkg::REQ_DELETE,  5'd4,  32'h0, 4'd1,  1'b1, 32'h0, iida_pkg::ST_RANGE, 5'd4},
    '{iida_pkg::REQ_DELETE,  5'd0,  32'h0, 4'd1,  1'b1, 32'h0, iida_pkg::ST_DONE,  5'd3},
    '{REQ_SPARE_HI,          5'd31, 32'hffff_ffff, 4'd1,  1'b1, 32'h0, iida_pkg::ST_DONE, 5'd3},
    '{iida_pkg::REQ_APPEND,  5'd0,  32'h1000, 4'd13, 1'b0, 32'h0, iida_pkg::ST_DONE,  5'd0},
    '{iida_pkg::REQ_APPEND,  5'd0,  32'h55, 4'd1,  1'b1, 32'h0, iida_pkg::ST_FULL,  5'd16},
    '{iida_pkg::REQ_PREPEND, 5'd0,  32'h66, 4'd1,  1'b1, 32'h0, iida_pkg::ST_FULL,  5'd16},
    '{iida_pkg::REQ_INSERT,  5'd16, 32'h77, 4'd1,  1'b1, 32'h0, iida_pkg::ST_FULL,  5'd16},
    '{iida_pkg::REQ_INSERT,  5'd17, 32'h88, 4'd1,  1'b1, 32'h0, iida_pkg::ST_RANGE, 5'd16},
    '{iida_pkg::REQ_READ,    5'd15, 32'h0, 4'd1,  1'b0, 32'h0, iida_pkg::ST_DONE,  5'd0},
    '{iida_pkg::REQ_READ,    5'd16, 32'h0, 4'd1,  1'b1, 32'h0, iida_pkg::ST_RANGE, 5'd16},
    '{iida_pkg::REQ_DELETE,  5'd15, 32'h0, 4'd1,  1'b1, 32'h0, iida_pkg::ST_DONE,  5'd15},
    '{iida_pkg::REQ_INSERT,  5'd0,  32'ha5a5_a5a5, 4'd1,  1'b0, 32'h0, iida_pkg::ST_DONE, 5'd0},
    '{iida_pkg::REQ_DELETE,  5'd31, 32'h0, 4'd1,  1'b1, 32'h0, iida_pkg::ST_RANGE, 5'd16}
  };

  // per mix (fill, drain, balanced): upper bounds for read/append/prepend/insert/delete
  int op_cut [3][5] = '{'{15, 45, 60, 85, 98},
                        '{15, 25, 35, 50, 98},
                        '{25, 40, 55, 75, 98}};

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic iida_pkg::status_t place_word(int at,
                                                   logic signed [iida_pkg::VAL_W-1:0] word);
    if (list_len >= LIST_DEPTH) return iida_pkg::ST_FULL;
    for (int i = list_len; i > at; i--) list_words[i] = list_words[i-1];
    list_words[at] = word;
    list_len++;
    if (list_len > peak_len) peak_len = list_len;
    return iida_pkg::ST_DONE;
  endfunction

  function automatic list_result_t apply_request(iida_pkg::req_code_t req,
                                                 logic [iida_pkg::POS_W-1:0] pos,
                                                 logic signed [iida_pkg::VAL_W-1:0] val);
    list_result_t r;
    r.value  = '0;
    r.status = iida_pkg::ST_DONE;
    case (req)
      iida_pkg::REQ_READ: begin
        if (pos < list_len) r.value = list_words[pos];
        else r.status = iida_pkg::ST_RANGE;
      end
      iida_pkg::REQ_APPEND:  r.status = place_word(list_len, val);
      iida_pkg::REQ_PREPEND: r.status = place_word(0, val);
      iida_pkg::REQ_INSERT: begin
        // index check wins over the full check
        if (pos > list_len) r.status = iida_pkg::ST_RANGE;
        else r.status = place_word(pos, val);
      end
      iida_pkg::REQ_DELETE: begin
        if (pos >= list_len) begin
          r.status = iida_pkg::ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      default: ;
    endcase
    r.len = list_len[iida_pkg::LEN_OUT_W-1:0];
    return r;
  endfunction

  task automatic push_request(iida_pkg::req_code_t req, logic [iida_pkg::POS_W-1:0] pos,
                              logic [iida_pkg::VAL_W-1:0] val,
                              logic typed, list_result_t typed_res);
    int           gap;
    list_result_t predicted;
    gap = send_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.req_type <= req;
    in_chan.position <= pos;
    in_chan.value_in <= val;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predicted = apply_request(req, pos, val);
    if (typed) pending_results.push_back(typed_res);
    else pending_results.push_back(predicted);
    requests_sent++;
  endtask

  // result side: random stalls, field-by-field compare against the oldest expectation
  initial begin
    int           stall;
    list_result_t want;
    out_chan.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_checked % 32 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
      stall = sink_quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      results_checked++;
      if (out_chan.status == iida_pkg::ST_FULL) full_hits++;
      if (out_chan.status == iida_pkg::ST_RANGE) range_hits++;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result with nothing pending: value %h status %0d len %0d",
                   out_chan.value_out, out_chan.status, out_chan.length_after);
      end else begin
        want = pending_results.pop_front();
        if (out_chan.value_out !== want.value || out_chan.status !== want.status ||
            out_chan.length_after !== want.len) begin
          failures++;
          if (failures <= 10)
            $display("result %0d: exp %h st %0d len %0d, got %h st %0d len %0d",
                     results_checked, want.value, want.status, want.len,
                     out_chan.value_out, out_chan.status, out_chan.length_after);
        end
      end
    end
  end

  initial begin
    int                         mix;
    int                         pick;
    int                         spread;
    iida_pkg::req_code_t        req;
    logic [iida_pkg::POS_W-1:0] pos;
    logic [iida_pkg::VAL_W-1:0] val;
    list_result_t               typed_res;

    cycles          = 0;
    requests_sent   = 0;
    results_checked = 0;
    failures        = 0;
    full_hits       = 0;
    range_hits      = 0;
    peak_len        = 0;
    list_len        = 0;
    send_quiet      = 1'b0;
    sink_quiet      = 1'b0;
    rst_n            = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.req_type = iida_pkg::REQ_READ;
    in_chan.position = '0;
    in_chan.value_in = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      typed_res = {plan[i].exp_value, plan[i].exp_status, plan[i].exp_len};
      for (int k = 0; k < plan[i].reps; k++)
        push_request(plan[i].req, plan[i].pos, iida_pkg::VAL_W'(plan[i].val + k),
                     plan[i].typed, typed_res);
    end
    directed_sent = requests_sent;

    mix = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) mix = $urandom_range(0, 2);
      if (n % 32 == 0) send_quiet = ($urandom_range(0, 3) == 0);

      pick = $urandom_range(0, 99);
      if (pick < op_cut[mix][0]) req = iida_pkg::REQ_READ;
      else if (pick < op_cut[mix][1]) req = iida_pkg::REQ_APPEND;
      else if (pick < op_cut[mix][2]) req = iida_pkg::REQ_PREPEND;
      else if (pick < op_cut[mix][3]) req = iida_pkg::REQ_INSERT;
      else if (pick < op_cut[mix][4]) req = iida_pkg::REQ_DELETE;
      else req = iida_pkg::req_code_t'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));

      // mostly indices near the live range, some past the end
      spread = $urandom_range(0, 19);
      if (spread < 14) pos = iida_pkg::POS_W'($urandom_range(0, list_len));
      else if (spread < 19) pos = iida_pkg::POS_W'($urandom_range(0, LIST_DEPTH));
      else pos = iida_pkg::POS_W'($urandom_range(0, 31));

      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: val = 32'h8000_0000;
          1: val = 32'h7fff_ffff;
          2: val = 32'h0000_0000;
          default: val = 32'hffff_ffff;
        endcase
      end else begin
        val = $urandom;
      end

      push_request(req, pos, val, 1'b0, '0);
    end
    in_chan.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    failures += pending_results.size();
    $display("%0d requests (%0d directed) transferred, %0d results compared", requests_sent,
             directed_sent, results_checked);
    $display("list reached %0d entries; %0d full rejections, %0d index errors, %0d mismatches",
             peak_len, full_hits, range_hits, failures);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/iida_pkg.sv
hw/rtl/iida_ifs.sv
hw/rtl/iida_cell.sv
hw/rtl/indexed_insert_delete_array.sv
tb/indexed_insert_delete_array_tb.sv
